// ===== hw/rtl/hwn_pkg.sv =====
// ----------------------------------------------------------------------------
// hwn_pkg
// Shared widths, codes and interface types for the histogram block.
// ----------------------------------------------------------------------------
package hwn_pkg;

    localparam int NUM_BINS = 32;
    localparam int ADDR_W   = $clog2(NUM_BINS);
    localparam int CNT_W    = $clog2(NUM_BINS + 1);
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 6;
    localparam int BU_W     = 6;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = COUNT_W + ADDR_W;
    localparam int FRAC_W   = 16;
    localparam int SHARE_W  = FRAC_W + 1;
    localparam int STATUS_W = 2;
    localparam int DIV_CW   = $clog2(SHARE_W + 1);

    localparam logic [BU_W-1:0] BINS_USED_RST = BU_W'(32);

    localparam logic [FUNC_W-1:0] FN_INC  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SET  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NORM = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SUM,
        S_NRD,
        S_NDAT,
        S_NDIV
    } t_state;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [COUNT_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_store_req;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] dividend;
        logic [TOTAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SHARE_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hw/rtl/hwn_bin_store.sv =====
// ----------------------------------------------------------------------------
// hwn_bin_store
// Bin count memory: one write and one registered read per cycle. Per-entry
// valid flags make every bin read as zero after reset until first written.
// ----------------------------------------------------------------------------
module hwn_bin_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hwn_pkg::t_store_req         i_req,
    output logic [hwn_pkg::COUNT_W-1:0] o_rdata
);
    import hwn_pkg::*;

    logic [COUNT_W-1:0]  r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_vld;
    logic [COUNT_W-1:0]  r_rdata;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ===== hw/rtl/hwn_divider.sv =====
// ----------------------------------------------------------------------------
// hwn_divider
// Bit-serial restoring divider: floor(count * 2^16 / total), one quotient bit
// per cycle. Needs count <= total, so the quotient fits in SHARE_W bits.
// ----------------------------------------------------------------------------
module hwn_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hwn_pkg::t_div_req i_req,
    output hwn_pkg::t_div_rsp o_rsp
);
    import hwn_pkg::*;

    logic [TOTAL_W-1:0] r_rem;
    logic               r_in;
    logic [SHARE_W-1:0] r_q;
    logic [DIV_CW-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [TOTAL_W:0]   trial;
    logic [TOTAL_W:0]   diff;
    logic               ge;

    // Leading quotient bits are known zero, so start with count >> 1 loaded.
    assign trial = {r_rem, r_in};
    assign ge    = (trial >= {1'b0, i_req.divisor});
    assign diff  = trial - {1'b0, i_req.divisor};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {{(TOTAL_W - COUNT_W + 1){1'b0}}, i_req.dividend[COUNT_W-1:1]};
            r_in  <= i_req.dividend[0];
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            r_in  <= 1'b0;
            r_q   <= {r_q[SHARE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt  <= DIV_CW'(SHARE_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== hw/rtl/hwn_ctrl.sv =====
// ----------------------------------------------------------------------------
// hwn_ctrl
// Operation sequencer: read-modify-write of single bins, summing sweep and
// per-bin division sweep for normalize, and the registered result port.
// ----------------------------------------------------------------------------
module hwn_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hwn_pkg::FUNC_W-1:0]   i_func,
    input  logic [hwn_pkg::IDX_W-1:0]    i_bin_index,
    input  logic [hwn_pkg::COUNT_W-1:0]  i_new_count,
    input  logic [hwn_pkg::CNT_W-1:0]    i_active,
    output logic                         o_busy,
    output hwn_pkg::t_store_req          o_store_req,
    input  logic [hwn_pkg::COUNT_W-1:0]  i_rdata,
    output hwn_pkg::t_div_req            o_div_req,
    input  hwn_pkg::t_div_rsp            i_div_rsp,
    output logic                         o_strobe,
    output logic [hwn_pkg::IDX_W-1:0]    o_out_index,
    output logic [hwn_pkg::COUNT_W-1:0]  o_bin_count,
    output logic [hwn_pkg::SHARE_W-1:0]  o_share,
    output logic [hwn_pkg::STATUS_W-1:0] o_status,
    output logic                         o_last_of_run
);
    import hwn_pkg::*;

    localparam int CMP_W = IDX_W + 1;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func;
    logic [IDX_W-1:0]    r_bin;
    logic [COUNT_W-1:0]  r_new;
    logic [CNT_W-1:0]    r_idx;
    logic [TOTAL_W-1:0]  r_total;
    logic [COUNT_W-1:0]  r_count;

    logic                r_strobe;
    logic [IDX_W-1:0]    r_out_index;
    logic [COUNT_W-1:0]  r_bin_count;
    logic [SHARE_W-1:0]  r_share;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;

    logic                n_strobe;
    logic [IDX_W-1:0]    n_out_index;
    logic [COUNT_W-1:0]  n_bin_count;
    logic [SHARE_W-1:0]  n_share;
    logic [STATUS_W-1:0] n_status;
    logic                n_last;

    logic                accept;
    logic                in_range;
    logic                is_last;
    logic                sum_done;
    logic                total_zero;
    logic [COUNT_W-1:0]  mod_val;

    assign accept     = i_start && (r_state == S_IDLE);
    assign in_range   = (CMP_W'(r_bin) < CMP_W'(i_active));
    assign is_last    = ((CNT_W + 1)'(r_idx) + 1'b1) == (CNT_W + 1)'(i_active);
    assign sum_done   = (r_idx == i_active);
    assign total_zero = (r_total == '0);

    always_comb begin
        case (r_func)
            FN_INC:  mod_val = (i_rdata == '1) ? i_rdata : i_rdata + 1'b1;
            FN_SET:  mod_val = r_new;
            default: mod_val = i_rdata;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_func == FN_NORM) ? S_SUM : S_MOD;
                end
            end
            S_MOD: n_state = S_IDLE;
            S_SUM: begin
                if (sum_done) begin
                    n_state = S_NRD;
                end
            end
            S_NRD: n_state = S_NDAT;
            S_NDAT: begin
                if (!total_zero) begin
                    n_state = S_NDIV;
                end else begin
                    n_state = is_last ? S_IDLE : S_NRD;
                end
            end
            S_NDIV: begin
                if (i_div_rsp.done) begin
                    n_state = is_last ? S_IDLE : S_NRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_store_req.we    = 1'b0;
        o_store_req.waddr = r_bin[ADDR_W-1:0];
        o_store_req.wdata = mod_val;
        o_store_req.raddr = r_idx[ADDR_W-1:0];
        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_rdata;
        o_div_req.divisor  = r_total;
        n_strobe    = 1'b0;
        n_out_index = IDX_W'(r_idx);
        n_bin_count = r_count;
        n_share     = '0;
        n_status    = ST_OK;
        n_last      = is_last;
        case (r_state)
            S_IDLE: begin
                o_store_req.raddr = (i_func == FN_NORM) ? '0 : i_bin_index[ADDR_W-1:0];
            end
            S_MOD: begin
                o_store_req.we = in_range && (r_func == FN_INC || r_func == FN_SET);
                n_strobe    = 1'b1;
                n_out_index = r_bin;
                n_bin_count = in_range ? mod_val : '0;
                n_status    = in_range ? ST_OK : ST_RANGE;
                n_last      = 1'b1;
            end
            S_NDAT: begin
                o_div_req.start = !total_zero;
                n_strobe        = total_zero;
                n_bin_count     = i_rdata;
                n_status        = ST_ZERO;
            end
            S_NDIV: begin
                n_strobe = i_div_rsp.done;
                n_share  = i_div_rsp.quot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_func  <= i_func;
                    r_bin   <= i_bin_index;
                    r_new   <= i_new_count;
                    r_idx   <= CNT_W'(1);
                    r_total <= '0;
                end
            end
            S_SUM: begin
                r_total <= r_total + TOTAL_W'(i_rdata);
                r_idx   <= sum_done ? '0 : r_idx + 1'b1;
            end
            S_NDAT: begin
                r_count <= i_rdata;
                if (total_zero) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_NDIV: begin
                if (i_div_rsp.done) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (n_strobe) begin
            r_out_index <= n_out_index;
            r_bin_count <= n_bin_count;
            r_share     <= n_share;
            r_status    <= n_status;
            r_last      <= n_last;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_out_index   = r_out_index;
    assign o_bin_count   = r_bin_count;
    assign o_share       = r_share;
    assign o_status      = r_status;
    assign o_last_of_run = r_last;

endmodule

// ===== hw/rtl/histogram_with_normalization.sv =====
// ----------------------------------------------------------------------------
// histogram_with_normalization
// Histogram of bin counts with increment, set, read and relative-frequency
// normalize.
// ----------------------------------------------------------------------------
// Timing: a command is taken when start is high and busy is low. Increment,
// set and read give one result, registered out of the modify step that
// follows acceptance, and the block is idle again once that step is done;
// the bin memory is read in the cycle of acceptance and written back in the
// next. Normalize first sweeps the memory to form the total (one bin per
// cycle), then handles each bin in turn: a memory read, a bit-serial divide
// and a step to take the quotient. When the total is zero there is no
// divide and each bin is only read. Results appear for one cycle under
// o_strobe and cannot be stalled, so the receiver must take every strobe.
// The store reads as zero straight after reset; there is no clearing pass.
module histogram_with_normalization (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [hwn_pkg::FUNC_W-1:0]   i_func,
    input  logic [hwn_pkg::IDX_W-1:0]    i_bin_index,
    input  logic [hwn_pkg::COUNT_W-1:0]  i_new_count,
    input  logic                         i_cfg_we,
    input  logic [hwn_pkg::BU_W-1:0]     i_cfg_wdata,
    output logic                         o_strobe,
    output logic [hwn_pkg::IDX_W-1:0]    o_out_index,
    output logic [hwn_pkg::COUNT_W-1:0]  o_bin_count,
    output logic [hwn_pkg::SHARE_W-1:0]  o_share,
    output logic [hwn_pkg::STATUS_W-1:0] o_status,
    output logic                         o_last_of_run
);
    import hwn_pkg::*;

    localparam int BU_CMP_W = (BU_W > CNT_W) ? BU_W : CNT_W;

    logic [BU_W-1:0]    r_bins_used;
    logic [CNT_W-1:0]   active;
    t_store_req         store_req;
    logic [COUNT_W-1:0] rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_used <= BINS_USED_RST;
        end else if (i_cfg_we) begin
            r_bins_used <= i_cfg_wdata;
        end
    end

    // zero acts as one bin, anything past the store acts as the full store
    always_comb begin
        if (r_bins_used == '0) begin
            active = CNT_W'(1);
        end else if (BU_CMP_W'(r_bins_used) > BU_CMP_W'(NUM_BINS)) begin
            active = CNT_W'(NUM_BINS);
        end else begin
            active = CNT_W'(r_bins_used);
        end
    end

    hwn_bin_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rdata (rdata)
    );

    hwn_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    hwn_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_func        (i_func),
        .i_bin_index   (i_bin_index),
        .i_new_count   (i_new_count),
        .i_active      (active),
        .o_busy        (busy),
        .o_store_req   (store_req),
        .i_rdata       (rdata),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_strobe      (o_strobe),
        .o_out_index   (o_out_index),
        .o_bin_count   (o_bin_count),
        .o_share       (o_share),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== hw/rtl/hwn_checker.sv =====
// ----------------------------------------------------------------------------
// hwn_checker
// Port-level checks for the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module hwn_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [hwn_pkg::FUNC_W-1:0]   i_func,
    input  logic                         o_strobe,
    input  logic [hwn_pkg::COUNT_W-1:0]  o_bin_count,
    input  logic [hwn_pkg::SHARE_W-1:0]  o_share,
    input  logic [hwn_pkg::STATUS_W-1:0] o_status,
    input  logic                         o_last_of_run
);
    import hwn_pkg::*;

    // single-bin transaction: busy in the cycle after acceptance, then its result
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != FN_NORM) |=> busy ##1 (o_strobe && o_last_of_run))
        else $error("single-bin transaction did not produce its result on time");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_RANGE) |->
            (o_last_of_run && o_bin_count == '0 && o_share == '0))
        else $error("out-of-range result carries data");

    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_ZERO) |-> (o_share == '0 && o_bin_count == '0))
        else $error("zero-total result has non-zero count or share");

    // a run that is not finished keeps the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_of_run) |-> busy)
        else $error("block idle in the middle of a normalize run");

    a_share_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_share <= SHARE_W'(1 << FRAC_W)))
        else $error("share above one");

endmodule

bind histogram_with_normalization hwn_checker u_hwn_checker (.*);

// ===== bench/histogram_with_normalization_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_with_normalization_tb
// Self-checking bench for the histogram block. A directed table covers reset
// contents, range errors, saturation and a zero-total normalize. Random
// commands then run under a sweep of bins-in-use settings. Every result is
// checked field by field against an in-bench histogram predictor, or for typed rows the table's count and status.
// ----------------------------------------------------------------------------
module histogram_with_normalization_tb;

    import hwn_pkg::*;

    localparam int RAND_PER_PHASE = 60;
    localparam int NUM_PHASES     = 7;

    typedef struct {
        logic [IDX_W-1:0]    idx;
        logic [COUNT_W-1:0]  count;
        logic [SHARE_W-1:0]  share;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_bin_result;

    // Directed row: the expected count and status are only used when typed is set.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [IDX_W-1:0]    idx;
        logic [COUNT_W-1:0]  value;
        logic                typed;
        logic [COUNT_W-1:0]  want_count;
        logic [STATUS_W-1:0] want_status;
    } t_cmd_row;

    localparam int NUM_ROWS = 19;
    localparam t_cmd_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{FN_NORM, 6'd0,  32'd0,          1'b0, 32'd0,          ST_OK},    // all zero
        '{FN_READ, 6'd0,  32'd0,          1'b1, 32'd0,          ST_OK},
        '{FN_READ, 6'd63, 32'd0,          1'b1, 32'd0,          ST_RANGE},
        '{FN_INC,  6'd32, 32'd0,          1'b1, 32'd0,          ST_RANGE},
        '{FN_SET,  6'd31, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_OK},
        '{FN_INC,  6'd31, 32'd0,          1'b1, 32'hFFFF_FFFF,  ST_OK},    // saturates
        '{FN_SET,  6'd0,  32'd0,          1'b1, 32'd0,          ST_OK},
        '{FN_INC,  6'd0,  32'h1234_5678,  1'b1, 32'd1,          ST_OK},
        '{FN_SET,  6'd1,  32'd5,          1'b1, 32'd5,          ST_OK},
        '{FN_SET,  6'd2,  32'hAAAA_AAAA,  1'b1, 32'hAAAA_AAAA,  ST_OK},
        '{FN_SET,  6'd3,  32'h5555_5555,  1'b1, 32'h5555_5555,  ST_OK},
        '{FN_READ, 6'd31, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_OK},
        '{FN_NORM, 6'd63, 32'hFFFF_FFFF,  1'b0, 32'd0,          ST_OK},
        '{FN_SET,  6'd63, 32'hDEAD_BEEF,  1'b1, 32'd0,          ST_RANGE},
        '{FN_SET,  6'd31, 32'd0,          1'b1, 32'd0,          ST_OK},
        '{FN_SET,  6'd2,  32'd0,          1'b1, 32'd0,          ST_OK},
        '{FN_SET,  6'd3,  32'd0,          1'b1, 32'd0,          ST_OK},
        '{FN_INC,  6'd5,  32'd0,          1'b1, 32'd1,          ST_OK},
        '{FN_NORM, 6'd0,  32'd0,          1'b0, 32'd0,          ST_OK}     // small total
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func;
    logic [IDX_W-1:0]     i_bin_index;
    logic [COUNT_W-1:0]   i_new_count;
    logic                 i_cfg_we;
    logic [BU_W-1:0]      i_cfg_wdata;
    logic                 o_strobe;
    logic [IDX_W-1:0]     o_out_index;
    logic [COUNT_W-1:0]   o_bin_count;
    logic [SHARE_W-1:0]   o_share;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last_of_run;

    histogram_with_normalization dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_bin_index   (i_bin_index),
        .i_new_count   (i_new_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_strobe      (o_strobe),
        .o_out_index   (o_out_index),
        .o_bin_count   (o_bin_count),
        .o_share       (o_share),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow histogram
    logic [COUNT_W-1:0] shadow_bins [NUM_BINS];
    logic [BU_W-1:0]    shadow_bins_used;
    t_bin_result        pending_results [$];

    int error_count   = 0;
    int checked_count = 0;
    int norm_runs     = 0;
    int zero_runs     = 0;
    int range_hits    = 0;
    int sat_hits      = 0;

    function automatic int bins_in_use();
        if (shadow_bins_used == '0)
            return 1;
        if (int'(shadow_bins_used) > NUM_BINS)
            return NUM_BINS;
        return int'(shadow_bins_used);
    endfunction

    // Apply one command to the shadow histogram and queue the results it causes.
    function automatic void predict_histogram(input logic [FUNC_W-1:0] fn,
                                              input logic [IDX_W-1:0] bidx,
                                              input logic [COUNT_W-1:0] value);
        int                n;
        logic [63:0]       total;
        logic [ADDR_W-1:0] baddr;
        t_bin_result       r;
        n = bins_in_use();
        baddr = bidx[ADDR_W-1:0];
        if (fn == FN_NORM) begin
            total = '0;
            for (int i = 0; i < n; i++)
                total += {32'd0, shadow_bins[i]};
            norm_runs++;
            if (total == '0)
                zero_runs++;
            for (int i = 0; i < n; i++) begin
                r.idx    = IDX_W'(i);
                r.count  = shadow_bins[i];
                r.share  = '0;
                r.status = ST_ZERO;
                if (total != '0) begin
                    r.share  = SHARE_W'(({32'd0, shadow_bins[i]} << FRAC_W) / total);
                    r.status = ST_OK;
                end
                r.last = (i == n - 1);
                pending_results.push_back(r);
            end
            return;
        end
        r.idx   = bidx;
        r.share = '0;
        r.last  = 1'b1;
        if (int'(bidx) >= n) begin
            r.count  = '0;
            r.status = ST_RANGE;
            range_hits++;
        end else begin
            if (fn == FN_INC) begin
                if (shadow_bins[baddr] == '1)
                    sat_hits++;
                else
                    shadow_bins[baddr] += 1;
            end else if (fn == FN_SET) begin
                shadow_bins[baddr] = value;
            end
            r.count  = shadow_bins[baddr];
            r.status = ST_OK;
        end
        pending_results.push_back(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with start still high.
    task automatic issue_cmd(input t_cmd_row row);
        t_bin_result r;
        start       <= 1'b1;
        i_func      <= row.func;
        i_bin_index <= row.idx;
        i_new_count <= row.value;
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        predict_histogram(row.func, row.idx, row.value);
        if (row.typed) begin
            r = pending_results.pop_back();
            r.count  = row.want_count;
            r.status = row.want_status;
            pending_results.push_back(r);
        end
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
    endtask

    task automatic write_bins_used(input logic [BU_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        shadow_bins_used = value;
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_cmd_row random_cmd();
        t_cmd_row c;
        int       pick;
        c = '0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.func = FN_INC;
        else if (pick < 60)
            c.func = FN_SET;
        else if (pick < 83)
            c.func = FN_READ;
        else
            c.func = FN_NORM;
        // Mostly in-range indexes so the counts build up
        if ($urandom_range(0, 9) < 7)
            c.idx = IDX_W'($urandom_range(0, bins_in_use() - 1));
        else
            c.idx = IDX_W'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
            0: c.value = 32'hFFFF_FFFF;
            1: c.value = 32'hFFFF_FFFE;
            2: c.value = 32'($urandom_range(0, 1000));
            3: c.value = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
            default: c.value = $urandom;
        endcase
        return c;
    endfunction

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_bin_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: index %0d count %0d", o_out_index,
                       o_bin_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (o_out_index !== want.idx) begin
                    $error("out_index: expected %0d, got %0d", want.idx, o_out_index);
                    error_count++;
                end
                if (o_bin_count !== want.count) begin
                    $error("bin_count: expected %0d, got %0d", want.count, o_bin_count);
                    error_count++;
                end
                if (o_share !== want.share) begin
                    $error("share: expected %0d, got %0d", want.share, o_share);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [BU_W-1:0] phase_cfg [NUM_PHASES];
        bit              quiet;
        phase_cfg = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd17, 6'd32, 6'd0};
        phase_cfg[NUM_PHASES-1] = BU_W'($urandom_range(3, 31));

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = FN_INC;
        i_bin_index = '0;
        i_new_count = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        foreach (shadow_bins[i])
            shadow_bins[i] = '0;
        shadow_bins_used = BINS_USED_RST;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            issue_cmd(DIRECTED_ROWS[i]);
            if ($urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 7));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_bins_used(phase_cfg[p]);
            quiet = (p == NUM_PHASES - 1);
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                issue_cmd(random_cmd());
                if (!quiet && $urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 7));
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Checked %0d results over %0d normalize runs (%0d with zero total).",
                 checked_count, norm_runs, zero_runs);
        $display("Range errors hit %0d times, saturated increments %0d times.",
                 range_hits, sat_hits);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
